[hw/rtl/sset_pkg.sv]
// Shared types and constants of the sorted set queue.
package sset_pkg;

	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	// Number of match flags folded into the hit flag per cycle.
	localparam int SCAN_WIDTH = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_POP    = 2'd2;

	typedef enum logic [2:0] {
		STATUS_DONE   = 3'd0,
		STATUS_EMPTY  = 3'd1,
		STATUS_FULL   = 3'd2,
		STATUS_DUP    = 3'd3,
		STATUS_ABSENT = 3'd4
	} status_t;

	// What every cell does with its entry in the apply cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     compare;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	typedef struct packed {
		logic last;
		logic hit;
	} scan_sts_t;

endpackage

[hw/rtl/sset_in_if.sv]
// Request channel of the sorted set queue: operation and value.
interface sset_in_if #(
	parameter int VALUE_WIDTH = sset_pkg::DEF_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

[hw/rtl/sset_out_if.sv]
// Result channel of the sorted set queue: popped value, status and entry count.
interface sset_out_if #(
	parameter int VALUE_WIDTH = sset_pkg::DEF_VALUE_WIDTH,
	parameter int COUNT_WIDTH = $clog2(sset_pkg::DEF_CAPACITY + 1)
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] popped_value;
	logic [2:0]                    status;
	logic [COUNT_WIDTH-1:0]        entry_count;

	modport source (output valid, output popped_value, output status, output entry_count,
		input ready);
	modport sink   (input valid, input popped_value, input status, input entry_count,
		output ready);
endinterface

[hw/rtl/sorted_set_queue.sv]
// Sorted set queue: bounded descending set of signed values used as a priority queue.
//
// The set lives in a row of CAPACITY cells, greatest value at the head, each cell
// holding one entry and comparing it with the request's value in parallel. A request
// passes through an accept cycle, a compare cycle in which every cell registers its
// greater and equal flags, scan cycles that fold the equal flags into a hit flag 32
// cells at a time, and an apply cycle in which the cells shift from their neighbours
// at once. The result goes to an output register, so the next request is taken while
// it waits; the apply cycle stalls only while a previous result is still held.
module sorted_set_queue #(
	parameter int CAPACITY    = sset_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = sset_pkg::DEF_VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sset_in_if.sink    req,
	sset_out_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CMP   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_APPLY = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [1:0]             op_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CW-1:0]          count_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] popped_q;
	sset_pkg::status_t      status_q;

	sset_pkg::cell_ctl_t    cell_ctl;
	sset_pkg::scan_ctl_t    scan_ctl;
	sset_pkg::scan_sts_t    scan_sts;

	logic [VALUE_WIDTH-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0]    gt_vec;
	logic [CAPACITY-1:0]    eq_vec;

	logic                   accept;
	logic                   emit;
	logic                   full;
	logic                   empty;
	sset_pkg::cell_op_t     apply_op;
	sset_pkg::status_t      apply_status;
	logic [CW-1:0]          next_count;

	assign accept = req.valid && req.ready;
	assign emit   = (state_q == S_APPLY) && (!out_valid_q || rsp.ready);
	assign full   = count_q == CW'(CAPACITY);
	assign empty  = count_q == '0;

	always_comb begin
		apply_op     = sset_pkg::CELL_HOLD;
		apply_status = sset_pkg::STATUS_DONE;
		next_count   = count_q;
		case (op_q)
			sset_pkg::OP_INSERT: begin
				if (scan_sts.hit) begin
					apply_status = sset_pkg::STATUS_DUP;
				end else if (full) begin
					apply_status = sset_pkg::STATUS_FULL;
				end else begin
					apply_op   = sset_pkg::CELL_INSERT;
					next_count = count_q + CW'(1);
				end
			end
			sset_pkg::OP_REMOVE: begin
				if (scan_sts.hit) begin
					apply_op   = sset_pkg::CELL_REMOVE;
					next_count = count_q - CW'(1);
				end else begin
					apply_status = sset_pkg::STATUS_ABSENT;
				end
			end
			sset_pkg::OP_POP: begin
				if (empty) begin
					apply_status = sset_pkg::STATUS_EMPTY;
				end else begin
					apply_op   = sset_pkg::CELL_POP;
					next_count = count_q - CW'(1);
				end
			end
			default: begin
				apply_op = sset_pkg::CELL_HOLD;
			end
		endcase
	end

	assign cell_ctl.compare = state_q == S_CMP;
	assign cell_ctl.op      = emit ? apply_op : sset_pkg::CELL_HOLD;
	assign scan_ctl.clear   = state_q == S_CMP;
	assign scan_ctl.step    = state_q == S_SCAN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_sts.last) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (emit) begin
						state_q <= S_IDLE;
						count_q <= next_count;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Values are held biased by the sign bit so that an unsigned compare orders them.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			key_q <= req.value ^ SIGN_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			popped_q <= (apply_op == sset_pkg::CELL_POP) ? (entries[0] ^ SIGN_BIT) : '0;
			status_q <= apply_status;
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = count_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   prev_gt;
		logic [VALUE_WIDTH-1:0] prev_entry;
		logic [VALUE_WIDTH-1:0] next_entry;

		if (i == 0) begin : g_head
			assign prev_gt    = 1'b1;
			assign prev_entry = '0;
		end else begin : g_body
			assign prev_gt    = gt_vec[i-1];
			assign prev_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = entries[i+1];
		end

		sset_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.COUNT_WIDTH (CW),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.key        (key_q),
			.count      (count_q),
			.prev_gt    (prev_gt),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (entries[i]),
			.gt         (gt_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	sset_scan #(
		.CAPACITY (CAPACITY)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.flags  (eq_vec),
		.sts    (scan_sts)
	);

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted request always moves straight on to the compare cycle.
	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CMP)
		else $error("accepted request did not reach compare");

	// A remove or pop that changes the set takes exactly one entry away.
	a_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (apply_op == sset_pkg::CELL_REMOVE || apply_op == sset_pkg::CELL_POP))
		|=> count_q == $past(count_q) - CW'(1))
		else $error("removal did not shrink the set by one");

	// A result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(status_q)))
		else $error("pending result overwritten");

endmodule

[hw/rtl/sset_cell.sv]
// One cell of the ordered chain: holds one biased entry and its compare flags.
module sset_cell #(
	parameter int VALUE_WIDTH = sset_pkg::DEF_VALUE_WIDTH,
	parameter int COUNT_WIDTH = $clog2(sset_pkg::DEF_CAPACITY + 1),
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sset_pkg::cell_ctl_t    ctl,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic                   prev_gt,
	input  logic [VALUE_WIDTH-1:0] prev_entry,
	input  logic [VALUE_WIDTH-1:0] next_entry,
	output logic [VALUE_WIDTH-1:0] entry,
	output logic                   gt,
	output logic                   eq
);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   gt_q;
	logic                   eq_q;
	logic                   occupied;

	assign occupied = count > COUNT_WIDTH'(INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.compare) begin
			gt_q <= occupied && (entry_q > key);
			eq_q <= occupied && (entry_q == key);
		end
	end

	// Cells holding a greater entry stay put; the rest shift towards the tail on an
	// insert and towards the head on a remove; a pop shifts every cell towards the head.
	always_ff @(posedge clk) begin
		case (ctl.op)
			sset_pkg::CELL_INSERT: begin
				if (!gt_q) begin
					entry_q <= prev_gt ? key : prev_entry;
				end
			end
			sset_pkg::CELL_REMOVE: begin
				if (!gt_q) begin
					entry_q <= next_entry;
				end
			end
			sset_pkg::CELL_POP: begin
				entry_q <= next_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	assign gt    = gt_q;
	assign eq    = eq_q;

endmodule

[hw/rtl/sset_scan.sv]
// Folds the cells' match flags into one hit flag, one slice per cycle while stepping.
module sset_scan #(
	parameter int CAPACITY = sset_pkg::DEF_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sset_pkg::scan_ctl_t   ctl,
	input  logic [CAPACITY-1:0]   flags,
	output sset_pkg::scan_sts_t   sts
);

	localparam int NUM_CHUNKS = (CAPACITY + sset_pkg::SCAN_WIDTH - 1) / sset_pkg::SCAN_WIDTH;
	localparam int CKW        = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

	logic [NUM_CHUNKS*sset_pkg::SCAN_WIDTH-1:0] flags_pad;
	logic [CKW-1:0]                             chunk_q;
	logic                                       hit_q;

	always_comb begin
		flags_pad = '0;
		flags_pad[CAPACITY-1:0] = flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			hit_q   <= 1'b0;
		end else if (ctl.clear) begin
			chunk_q <= '0;
			hit_q   <= 1'b0;
		end else if (ctl.step) begin
			chunk_q <= chunk_q + CKW'(1);
			hit_q   <= hit_q | (|flags_pad[chunk_q*sset_pkg::SCAN_WIDTH +: sset_pkg::SCAN_WIDTH]);
		end
	end

	assign sts.last = chunk_q == CKW'(NUM_CHUNKS - 1);
	assign sts.hit  = hit_q;

endmodule
